// ----- rtl/lbp_pkg.sv -----
// Shared types and constants for the 3x3 local binary pattern block.
package lbp_pkg;

	// Field widths
	localparam int PIX_W  = 8;
	localparam int CODE_W = 8;
	localparam int WID_W  = 11;
	localparam int HGT_W  = 13;
	localparam int ROW_W  = 12;

	// Image size limits and reset values
	localparam int DIM_MIN      = 3;
	localparam int HEIGHT_MAX   = 4096;
	localparam int WIDTH_RESET  = 100;
	localparam int HEIGHT_RESET = 100;

	// Register indexes (word address)
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Code bit positions, top-left then clockwise
	localparam int BIT_TL = 7;
	localparam int BIT_T  = 6;
	localparam int BIT_TR = 5;
	localparam int BIT_R  = 4;
	localparam int BIT_BR = 3;
	localparam int BIT_B  = 2;
	localparam int BIT_BL = 1;
	localparam int BIT_L  = 0;

	// Result queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} queue_stat_t;

endpackage

// ----- rtl/lbp_if.sv -----
// Valid/ready stream interfaces for pixels in and pattern codes out.
interface lbp_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface lbp_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] pattern_code;
	logic       frame_last;

	modport source (output valid, output pattern_code, output frame_last, input ready);
	modport sink (input valid, input pattern_code, input frame_last, output ready);
endinterface

// ----- rtl/lbp_front.sv -----
// Front end: accepts pixels, tracks position, reads line buffers, forms codes.
module lbp_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lbp_pixel_if.sink                  pixels,
	input  logic [lbp_pkg::WID_W-1:0]  width_cfg,
	input  logic [lbp_pkg::HGT_W-1:0]  height_cfg,
	input  lbp_pkg::queue_stat_t       q_stat,
	output logic                       push,
	output lbp_pkg::result_t           push_data
);
	import lbp_pkg::*;

	localparam int CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
	localparam int CMPW = ((CW > WID_W) ? CW : WID_W) + 1;

	// Position counters
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	// Stage 1: item whose line reads are under way
	logic             valid_s1;
	logic             emit_s1;
	logic             last_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [CW-1:0]    addr_s1;
	logic [PIX_W-1:0] top_s1;
	logic [PIX_W-1:0] mid_s1;

	// Line buffers and window
	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [PIX_W-1:0] win_q [6];

	logic [CMPW-1:0]  w_eff;
	logic [HGT_W-1:0] h_eff;
	logic [CMPW-1:0]  col_inc;
	logic [HGT_W-1:0] row_inc;
	logic             row_end;
	logic             img_end;
	logic             emit;
	logic             accept;
	logic [PIX_W-1:0] ctr;
	logic [CODE_W-1:0] code;

	// Clamp configured size into the legal range
	always_comb begin
		if (CMPW'(width_cfg) < CMPW'(DIM_MIN)) begin
			w_eff = CMPW'(DIM_MIN);
		end else if (CMPW'(width_cfg) > CMPW'(MAX_WIDTH)) begin
			w_eff = CMPW'(MAX_WIDTH);
		end else begin
			w_eff = CMPW'(width_cfg);
		end
		if (height_cfg < HGT_W'(DIM_MIN)) begin
			h_eff = HGT_W'(DIM_MIN);
		end else if (height_cfg > HGT_W'(HEIGHT_MAX)) begin
			h_eff = HGT_W'(HEIGHT_MAX);
		end else begin
			h_eff = height_cfg;
		end
	end

	// Classify the incoming pixel by position
	assign col_inc = CMPW'(col_q) + CMPW'(1);
	assign row_inc = HGT_W'(row_q) + HGT_W'(1);
	assign row_end = col_inc >= w_eff;
	assign img_end = row_inc >= h_eff;
	assign emit    = (row_q >= ROW_W'(2)) && (col_q >= CW'(2));

	// Room for the stage 1 result and this one
	assign pixels.ready = (q_stat.count + QCNT_W'(valid_s1 & emit_s1)) < QCNT_W'(QUEUE_DEPTH);
	assign accept       = pixels.valid && pixels.ready;

	// Counters wrap at row and image end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= img_end ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				emit_s1 <= emit;
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= img_end && row_end;
			pix_s1  <= pixels.pixel;
			addr_s1 <= col_q;
		end
	end

	// Middle line: read old entry, store the new pixel at the same column
	always_ff @(posedge clk) begin
		if (accept) begin
			mid_s1              <= middle_mem[col_q];
			middle_mem[col_q] <= pixels.pixel;
		end
	end

	// Upper line: old middle entry moves up once it has been read
	always_ff @(posedge clk) begin
		if (accept) begin
			top_s1 <= upper_mem[col_q];
		end
		if (valid_s1) begin
			upper_mem[addr_s1] <= mid_s1;
		end
	end

	// Window shifts by one column per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (valid_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= top_s1;
			win_q[2] <= win_q[3];
			win_q[3] <= mid_s1;
			win_q[4] <= win_q[5];
			win_q[5] <= pix_s1;
		end
	end

	// Neighbor compares against the center
	assign ctr = win_q[3];
	always_comb begin
		code         = '0;
		code[BIT_TL] = win_q[0] > ctr;
		code[BIT_T]  = win_q[1] > ctr;
		code[BIT_TR] = top_s1 > ctr;
		code[BIT_R]  = mid_s1 > ctr;
		code[BIT_BR] = pix_s1 > ctr;
		code[BIT_B]  = win_q[5] > ctr;
		code[BIT_BL] = win_q[4] > ctr;
		code[BIT_L]  = win_q[2] > ctr;
	end

	assign push           = valid_s1 && emit_s1;
	assign push_data.code = code;
	assign push_data.last = last_s1;

endmodule

// ----- rtl/lbp_queue.sv -----
// Small result queue between front and back ends.
module lbp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lbp_pkg::result_t      push_data,
	input  logic                  pop,
	output lbp_pkg::result_t      pop_data,
	output lbp_pkg::queue_stat_t  stat
);
	import lbp_pkg::*;

	result_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign pop_data   = slot_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign stat.empty = count_q == '0;

endmodule

// ----- rtl/lbp_back.sv -----
// Back end: moves queued results into the output register.
module lbp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lbp_pkg::queue_stat_t  q_stat,
	input  lbp_pkg::result_t      q_data,
	output logic                  pop,
	lbp_code_if.source            codes
);
	import lbp_pkg::*;

	logic    out_valid_q;
	result_t out_q;

	// Load whenever the register is empty or being drained
	assign pop = !q_stat.empty && (!out_valid_q || codes.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || codes.ready) begin
			out_valid_q <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= q_data;
		end
	end

	assign codes.valid        = out_valid_q;
	assign codes.pattern_code = out_q.code;
	assign codes.frame_last   = out_q.last;

endmodule

// ----- rtl/lbp_3x3_raster.sv -----
// Top level of the 3x3 local binary pattern block over a raster pixel stream.
//
//   port     dir  handshake      payload
//   pixels   in   valid/ready    pixel[7:0]
//   codes    out  valid/ready    pattern_code[7:0], frame_last
//   apb      in   psel/penable   image_width @0x0, image_height @0x4
//
// One pixel per cycle sustained while the queue has room; the code for the pixel
// that completes its window passes line buffer read and compare, queue, output register.
// Each line buffer has one read and one write port; the read is registered
// into stage 1. A 4-entry queue decouples the compare from the output register,
// so output stalls hold pixels off only once it fills, counting the stage 1 result.
// Reset clears counters, window and queue; line buffers are not cleared.
module lbp_3x3_raster #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	lbp_pixel_if.sink   pixels,
	lbp_code_if.source  codes,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lbp_pkg::*;

	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	logic             cfg_wr;
	logic             push;
	logic             pop;
	result_t          push_data;
	result_t          pop_data;
	queue_stat_t      q_stat;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(WIDTH_RESET);
			height_q <= HGT_W'(HEIGHT_RESET);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[WID_W-1:0];
				REG_HEIGHT: height_q <= pwdata[HGT_W-1:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			default:    prdata = '0;
		endcase
	end

	lbp_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pixels),
		.width_cfg  (width_q),
		.height_cfg (height_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_data  (push_data)
	);

	lbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	lbp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_data (pop_data),
		.pop    (pop),
		.codes  (codes)
	);

	// Queue is never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("result queue overflow");

	// Nothing appears at the output without a queued result behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.empty && !codes.valid) |=> !codes.valid)
		else $error("output valid without queued result");

	// A push that is not drained leaves the queue non-empty
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !q_stat.empty)
		else $error("pushed result lost");

endmodule
